// ----- sv/xbin_cell_stream_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// xbin cell stream decoder assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef XBIN_CELL_STREAM_DECODER_UNIT_DEFINES_SVH
`define XBIN_CELL_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define XBIN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XBIN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/xbin_pkg.sv -----
// ----------------------------------------------------------------------------
// xbin_pkg
// types and constants shared by the cell stream decoder modules
// ----------------------------------------------------------------------------
package xbin_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned REM_W      = 7;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned KIND_SHIFT = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam logic [BYTE_W-1:0] LEN_MASK = 8'o77;

	typedef enum logic [KIND_W-1:0] {
		RUN_PAIRS = 2'd0,
		RUN_CHAR  = 2'd1,
		RUN_ATTR  = 2'd2,
		RUN_BOTH  = 2'd3
	} run_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMPRESSED = 2'd0,
		CFG_TOTAL      = 2'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_CODE,
		ST_ATTR,
		ST_BURST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_header;
		logic hold_code;
		logic hold_attr;
		logic emit;
		logic code_from_byte;
		logic attr_from_byte;
		logic last;
		logic dec_run;
	} cmd_t;

	typedef struct packed {
		run_kind_t kind;
		run_kind_t byte_kind;
		logic      rem_le1;
		logic      reached_next;
		logic      total_zero;
		logic      compressed;
		logic      slot_free;
	} sts_t;

endpackage

// ----- sv/xbin_cell_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// xbin_cell_stream_decoder_unit
// run-length text-mode image decoder: bytes in, character cells out
// ----------------------------------------------------------------------------
// input channel: one stream_byte per request (in_valid / in_stall).
// output channel: one cell per request (out_valid / out_stall) carrying
//   char_code, cell_attribute, run_last (last cell of its byte) and
//   image_complete (cell that reaches total_cells).
// config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 selects
//   compressed_mode, 1 total_cells; a write to either restarts decoding.
// a cell is registered on the output in the cycle after the byte that makes it;
//   the cells of a repeated run are made by the burst state after its attribute byte.
// throughput: one byte per cycle while the output keeps up; a header byte or
//   a held code or attribute byte makes no cell. a repeated run of 1..64 cells
//   stalls the input after its attribute byte while the burst sequencer fills
//   the single output register one cell per cycle while the output keeps up.
// a stalled output holds its cell; bytes that need the output slot wait,
//   bytes that only load state are still taken.
// reset: compressed mode, total of one cell, header phase, count zero.
// once the image is complete (or the total is zero) bytes are taken and
//   dropped until a configuration write restarts decoding with a non-zero total.
// ----------------------------------------------------------------------------
module xbin_cell_stream_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [xbin_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xbin_pkg::COUNT_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [xbin_pkg::BYTE_W-1:0]     stream_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [xbin_pkg::BYTE_W-1:0]     char_code,
	output logic [xbin_pkg::BYTE_W-1:0]     cell_attribute,
	output logic                            run_last,
	output logic                            image_complete
);
	import xbin_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic restart;

	assign cfg_ready = 1'b1;

	xbin_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	xbin_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.restart        (restart),
		.stream_byte    (stream_byte),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.char_code      (char_code),
		.cell_attribute (cell_attribute),
		.run_last       (run_last),
		.image_complete (image_complete)
	);

endmodule

// ----- sv/xbin_ctrl.sv -----
// ----------------------------------------------------------------------------
// xbin_ctrl
// byte phase state machine: decides what each byte does and drives the burst
// ----------------------------------------------------------------------------
module xbin_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	input  logic          in_valid,
	output logic          in_stall,
	input  xbin_pkg::sts_t sts,
	output xbin_pkg::cmd_t cmd
);
	import xbin_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else if (restart) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b0;
		if (!sts.total_zero) begin
			case (state_q)
				ST_HEADER: begin
					if (in_valid && !in_stall) begin
						if (sts.compressed) begin
							cmd.load_header = 1'b1;
							state_d = (sts.byte_kind == RUN_ATTR) ? ST_ATTR : ST_CODE;
						end else begin
							// plain pairs: header phase takes a code byte
							cmd.hold_code = 1'b1;
							state_d = ST_ATTR;
						end
					end
				end
				ST_CODE: begin
					if (sts.compressed && sts.kind == RUN_ATTR) begin
						in_stall = !sts.slot_free;
						if (in_valid && !in_stall) begin
							cmd.emit = 1'b1;
							cmd.code_from_byte = 1'b1;
							cmd.last = 1'b1;
							cmd.dec_run = 1'b1;
							if (sts.rem_le1) begin
								state_d = sts.reached_next ? ST_DONE : ST_HEADER;
							end
						end
					end else if (in_valid && !in_stall) begin
						cmd.hold_code = 1'b1;
						state_d = ST_ATTR;
					end
				end
				ST_ATTR: begin
					if (!sts.compressed) begin
						in_stall = !sts.slot_free;
						if (in_valid && !in_stall) begin
							cmd.emit = 1'b1;
							cmd.attr_from_byte = 1'b1;
							cmd.last = 1'b1;
							state_d = sts.reached_next ? ST_DONE : ST_CODE;
						end
					end else if (sts.kind == RUN_ATTR) begin
						if (in_valid && !in_stall) begin
							cmd.hold_attr = 1'b1;
							state_d = ST_CODE;
						end
					end else if (sts.kind == RUN_BOTH) begin
						if (in_valid && !in_stall) begin
							cmd.hold_attr = 1'b1;
							state_d = ST_BURST;
						end
					end else begin
						in_stall = !sts.slot_free;
						if (in_valid && !in_stall) begin
							cmd.emit = 1'b1;
							cmd.attr_from_byte = 1'b1;
							cmd.hold_attr = 1'b1;
							cmd.last = 1'b1;
							cmd.dec_run = 1'b1;
							if (sts.rem_le1) begin
								state_d = sts.reached_next ? ST_DONE : ST_HEADER;
							end else begin
								state_d = (sts.kind == RUN_PAIRS) ? ST_CODE : ST_ATTR;
							end
						end
					end
				end
				ST_BURST: begin
					// repeated cell, one per free output slot
					in_stall = 1'b1;
					if (sts.slot_free) begin
						cmd.emit = 1'b1;
						cmd.last = sts.rem_le1;
						cmd.dec_run = 1'b1;
						if (sts.rem_le1) begin
							state_d = sts.reached_next ? ST_DONE : ST_HEADER;
						end
					end
				end
				ST_DONE: begin
					// image complete: bytes are dropped
				end
				default: begin
					state_d = ST_HEADER;
				end
			endcase
		end
	end

endmodule

// ----- sv/xbin_datapath.sv -----
// ----------------------------------------------------------------------------
// xbin_datapath
// configuration, run registers, held code and attribute, cell count and
// the output register
// ----------------------------------------------------------------------------
module xbin_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xbin_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xbin_pkg::COUNT_W-1:0]    cfg_data,
	output logic                            restart,
	input  logic [xbin_pkg::BYTE_W-1:0]     stream_byte,
	input  xbin_pkg::cmd_t                  cmd,
	output xbin_pkg::sts_t                  sts,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [xbin_pkg::BYTE_W-1:0]     char_code,
	output logic [xbin_pkg::BYTE_W-1:0]     cell_attribute,
	output logic                            run_last,
	output logic                            image_complete
);
	import xbin_pkg::*;

	logic                compressed_q;
	logic [COUNT_W-1:0]  total_q;
	run_kind_t           run_kind_q;
	logic [REM_W-1:0]    run_rem_q;
	logic [BYTE_W-1:0]   held_code_q;
	logic [BYTE_W-1:0]   held_attr_q;
	logic [COUNT_W-1:0]  cells_done_q;
	logic                reached_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   char_code_q;
	logic [BYTE_W-1:0]   cell_attr_q;
	logic                run_last_q;
	logic                complete_q;
	logic                completes;
	logic [COUNT_W:0]    count_inc;
	logic [BYTE_W-1:0]   len_field;

	assign restart = cfg_we &&
		(cfg_index == CFG_COMPRESSED || cfg_index == CFG_TOTAL);

	assign count_inc = {1'b0, cells_done_q} + {{COUNT_W{1'b0}}, 1'b1};
	// the cell that lifts the count onto the total
	assign completes = (count_inc == {1'b0, total_q});
	assign len_field = stream_byte & LEN_MASK;

	assign sts.kind         = run_kind_q;
	assign sts.byte_kind    = run_kind_t'(stream_byte[KIND_SHIFT +: KIND_W]);
	assign sts.rem_le1      = (run_rem_q <= REM_W'(1));
	// only looked at alongside an emitted cell
	assign sts.reached_next = reached_q || completes;
	assign sts.total_zero   = (total_q == '0);
	assign sts.compressed   = compressed_q;
	assign sts.slot_free    = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q <= 1'b1;
			total_q      <= COUNT_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_COMPRESSED) begin
				compressed_q <= cfg_data[0];
			end else if (cfg_index == CFG_TOTAL) begin
				total_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_kind_q   <= RUN_PAIRS;
			run_rem_q    <= '0;
			held_code_q  <= '0;
			held_attr_q  <= '0;
			cells_done_q <= '0;
			reached_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (restart) begin
			run_kind_q   <= RUN_PAIRS;
			run_rem_q    <= '0;
			held_code_q  <= '0;
			held_attr_q  <= '0;
			cells_done_q <= '0;
			reached_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_header) begin
				run_kind_q <= sts.byte_kind;
				run_rem_q  <= len_field[REM_W-1:0] + REM_W'(1);
			end else if (cmd.dec_run && run_rem_q != '0) begin
				run_rem_q <= run_rem_q - REM_W'(1);
			end
			if (cmd.hold_code) begin
				held_code_q <= stream_byte;
			end
			if (cmd.hold_attr) begin
				held_attr_q <= stream_byte;
			end
			if (cmd.emit) begin
				if (cells_done_q != '1) begin
					cells_done_q <= count_inc[COUNT_W-1:0];
				end
				if (completes) begin
					reached_q <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_code_q <= cmd.code_from_byte ? stream_byte : held_code_q;
			cell_attr_q <= cmd.attr_from_byte ? stream_byte : held_attr_q;
			run_last_q  <= cmd.last;
			complete_q  <= completes;
		end
	end

	assign out_valid      = out_valid_q;
	assign char_code      = char_code_q;
	assign cell_attribute = cell_attr_q;
	assign run_last       = run_last_q;
	assign image_complete = complete_q;

endmodule

// ----- sv/xbin_cell_stream_decoder_unit_checker.sv -----
// ----------------------------------------------------------------------------
// xbin_cell_stream_decoder_unit_checker
// port-level checks on the output register and the repeated-run burst
// ----------------------------------------------------------------------------
`include "xbin_cell_stream_decoder_unit_defines.svh"

module xbin_cell_stream_decoder_unit_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [xbin_pkg::BYTE_W-1:0]     char_code,
	input logic [xbin_pkg::BYTE_W-1:0]     cell_attribute,
	input logic                            run_last,
	input logic                            image_complete
);
	import xbin_pkg::*;

	logic restart;

	assign restart = cfg_valid && cfg_ready;

	// a stalled cell holds
	`XBIN_ASSERT_NXT(a_out_hold, out_valid && out_stall && !restart,
		out_valid && $stable(char_code) && $stable(cell_attribute) && $stable(run_last) && $stable(image_complete),
		"stalled output cell changed")

	// a non-last cell means a burst is running, so no byte may enter
	`XBIN_ASSERT_IMP(a_burst_blocks_input, out_valid && !run_last, in_stall,
		"byte taken during a repeated run")

	// a burst refills the output register without a gap
	`XBIN_ASSERT_NXT(a_burst_no_gap, out_valid && !out_stall && !run_last && !restart,
		out_valid, "gap inside a repeated run")

endmodule

bind xbin_cell_stream_decoder_unit xbin_cell_stream_decoder_unit_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.char_code      (char_code),
	.cell_attribute (cell_attribute),
	.run_last       (run_last),
	.image_complete (image_complete)
);

// ----- bench/tb_xbin_cell_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xbin_cell_stream_decoder_unit
// feeds image bytes to the decoder under random gaps and output back-pressure,
// walks a short table of hand-picked cases, then random run sequences, and
// checks every cell against a behavioural decoder that follows accepted bytes
// ----------------------------------------------------------------------------
module tb_xbin_cell_stream_decoder_unit;
	import xbin_pkg::*;

	localparam int          SETTLE_CYCLES   = 70;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          RANDOM_BYTES    = 500;
	localparam logic [31:0] TOTAL_MAX       = 32'd4294836225;

	typedef enum logic [1:0] {WANT_HEADER, WANT_CODE, WANT_ATTR} want_t;
	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [7:0] code;
		logic [7:0] attr;
		logic       last;
		logic       complete;
	} cell_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_idx_t    idx;
		logic [31:0] value;
		logic        typed;
		cell_t       typed_cell;
	} row_t;

	localparam cell_t NONE = '0;

	localparam row_t DIRECTED [30] = '{
		// zero total: everything dropped
		'{ROW_CFG,  CFG_TOTAL,      32'd0,    1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'hff,   1'b0, NONE},
		'{ROW_CFG,  CFG_TOTAL,      32'd1000, 1'b0, NONE},
		// pair run of one
		'{ROW_BYTE, CFG_COMPRESSED, 32'h00,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h00,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'hff,   1'b1, '{8'h00, 8'hff, 1'b1, 1'b0}},
		// longest repeated run, 64 cells from one byte
		'{ROW_BYTE, CFG_COMPRESSED, 32'hff,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'haa,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h55,   1'b0, NONE},
		// repeated character
		'{ROW_BYTE, CFG_COMPRESSED, 32'h40,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h20,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h07,   1'b1, '{8'h20, 8'h07, 1'b1, 1'b0}},
		// repeated attribute, two codes
		'{ROW_BYTE, CFG_COMPRESSED, 32'h81,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h1e,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h01,   1'b1, '{8'h01, 8'h1e, 1'b1, 1'b0}},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h02,   1'b1, '{8'h02, 8'h1e, 1'b1, 1'b0}},
		// plain pairs, first byte lands in the header phase
		'{ROW_CFG,  CFG_COMPRESSED, 32'd0,    1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h12,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h34,   1'b1, '{8'h12, 8'h34, 1'b1, 1'b0}},
		'{ROW_CFG,  CFG_TOTAL,      32'd2,    1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h05,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h06,   1'b1, '{8'h05, 8'h06, 1'b1, 1'b0}},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h07,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h08,   1'b1, '{8'h07, 8'h08, 1'b1, 1'b1}},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h09,   1'b0, NONE},
		// run of five crossing a total of two, then ignored
		'{ROW_CFG,  CFG_COMPRESSED, 32'd1,    1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'hc4,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h33,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h44,   1'b0, NONE},
		'{ROW_BYTE, CFG_COMPRESSED, 32'h00,   1'b0, NONE}
	};

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [COUNT_W-1:0]   cfg_data       = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    stream_byte    = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [BYTE_W-1:0]    char_code;
	logic [BYTE_W-1:0]    cell_attribute;
	logic                 run_last;
	logic                 image_complete;

	int   errors       = 0;
	int   bytes_sent   = 0;
	logic no_gaps      = 1'b0;
	logic hold_off_req = 1'b0;

	// decoder state as the block should hold it
	logic        mode_rle;
	logic [31:0] image_total;
	want_t       want;
	run_kind_t   kind_now;
	logic [6:0]  left;
	logic [7:0]  held_code;
	logic [7:0]  held_attr;
	logic [31:0] cells_done;
	logic        done;

	cell_t fresh_cells[$];
	cell_t expected_cells[$];

	xbin_cell_stream_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.stream_byte    (stream_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.char_code      (char_code),
		.cell_attribute (cell_attribute),
		.run_last       (run_last),
		.image_complete (image_complete)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function void restart_decoder();
		want       = WANT_HEADER;
		kind_now   = RUN_PAIRS;
		left       = '0;
		held_code  = '0;
		held_attr  = '0;
		cells_done = '0;
		done       = 1'b0;
	endfunction

	function void push_cell(logic [7:0] code, logic [7:0] attr);
		cell_t       c;
		logic [31:0] prior;
		prior = cells_done;
		if (cells_done != '1)
			cells_done++;
		c.code     = code;
		c.attr     = attr;
		c.last     = 1'b0;
		c.complete = (prior < image_total) && (cells_done >= image_total);
		fresh_cells.push_back(c);
	endfunction

	function void close_run_step();
		if (left != 0)
			left--;
		if (left == 0) begin
			want = WANT_HEADER;
			if (cells_done >= image_total)
				done = 1'b1;
		end
	endfunction

	// returns 1 when the byte is used, 0 when the block drops it
	function logic decode_stream_byte(logic [7:0] b);
		cell_t tail;
		fresh_cells.delete();
		if (done || image_total == 0)
			return 1'b0;
		if (!mode_rle) begin
			if (want == WANT_ATTR) begin
				push_cell(held_code, b);
				want = WANT_CODE;
				if (cells_done >= image_total)
					done = 1'b1;
			end else begin
				held_code = b;
				want      = WANT_ATTR;
			end
		end else if (want == WANT_CODE) begin
			if (kind_now == RUN_ATTR) begin
				push_cell(b, held_attr);
				close_run_step();
			end else begin
				held_code = b;
				want      = WANT_ATTR;
			end
		end else if (want == WANT_ATTR) begin
			held_attr = b;
			if (kind_now == RUN_ATTR) begin
				want = WANT_CODE;
			end else if (kind_now == RUN_BOTH) begin
				while (left != 0) begin
					push_cell(held_code, b);
					left--;
				end
				left = 7'd1;
				close_run_step();
			end else begin
				push_cell(held_code, b);
				close_run_step();
				if (kind_now == RUN_PAIRS && want != WANT_HEADER)
					want = WANT_CODE;
			end
		end else begin
			kind_now = run_kind_t'(b[KIND_SHIFT +: KIND_W]);
			left     = 7'(b & LEN_MASK) + 7'd1;
			want     = (kind_now == RUN_ATTR) ? WANT_ATTR : WANT_CODE;
		end
		if (fresh_cells.size() != 0) begin
			tail      = fresh_cells.pop_back();
			tail.last = 1'b1;
			fresh_cells.push_back(tail);
		end
		return 1'b1;
	endfunction

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_byte(logic [7:0] b, logic typed, cell_t typed_cell);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		stream_byte = b;
		do @(posedge clk); while (in_stall);
		void'(decode_stream_byte(b));
		bytes_sent++;
		if (typed)
			expected_cells.push_back(typed_cell);
		else
			foreach (fresh_cells[i])
				expected_cells.push_back(fresh_cells[i]);
		@(negedge clk);
	endtask

	// only once the block has drained and settled
	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		in_valid = 1'b0;
		while (expected_cells.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_COMPRESSED)
			mode_rle = value[0];
		else
			image_total = value;
		restart_decoder();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function void check_field(string what, logic [7:0] due, logic [7:0] seen);
		if (due !== seen) begin
			$display("%0t: %s expected %h got %h", $time, what, due, seen);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cell_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_cells.size() == 0) begin
				$display("%0t: cell not expected, got code %h attr %h last %b complete %b",
					$time, char_code, cell_attribute, run_last, image_complete);
				errors++;
			end else begin
				due = expected_cells.pop_front();
				check_field("char_code", due.code, char_code);
				check_field("cell_attribute", due.attr, cell_attribute);
				check_field("run_last", 8'(due.last), 8'(run_last));
				check_field("image_complete", 8'(due.complete), 8'(image_complete));
			end
		end
	end

	// receiver: random hold-off per request, one long hold on demand
	initial begin
		int wait_cycles;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall    = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				wait_cycles = no_gaps ? 0 : $urandom_range(0, 12);
				if (wait_cycles != 0) begin
					out_stall = 1'b1;
					repeat (wait_cycles) @(negedge clk);
				end
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!(arst_n && out_valid));
			@(negedge clk);
		end
	end

	initial begin
		row_t        r;
		int          goal;
		int          sent;
		int          len;
		int          n_bytes;
		int          n_phase;
		run_kind_t   k;
		logic [31:0] tot;
		logic [31:0] mode_word;

		mode_rle    = 1'b1;
		image_total = 32'd1;
		restart_decoder();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			r = DIRECTED[i];
			if (r.kind == ROW_CFG)
				write_reg(r.idx, r.value);
			else
				send_byte(r.value[7:0], r.typed, r.typed_cell);
		end

		n_phase = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (n_phase == 1) begin
				// long output hold while bytes keep coming, so the input backs up
				write_reg(CFG_COMPRESSED, 32'd1);
				write_reg(CFG_TOTAL, TOTAL_MAX);
				no_gaps      = 1'b1;
				hold_off_req = 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: tot = $urandom_range(1, 64);
					6, 7:             tot = $urandom_range(65, 400);
					8:                tot = $urandom_range(1, TOTAL_MAX);
					default:          tot = ($urandom_range(0, 1) != 0) ? TOTAL_MAX : 32'd1;
				endcase
				mode_word = {31'($urandom()), 1'($urandom_range(0, 3) != 0)};
				if ($urandom_range(0, 1) != 0) begin
					write_reg(CFG_TOTAL, tot);
					write_reg(CFG_COMPRESSED, mode_word);
				end else begin
					write_reg(CFG_COMPRESSED, mode_word);
					write_reg(CFG_TOTAL, tot);
				end
			end

			sent = 0;
			goal = $urandom_range(20, 70);
			while (sent < goal) begin
				if (!mode_rle || $urandom_range(0, 9) == 0) begin
					send_byte(8'($urandom_range(0, 255)), 1'b0, NONE);
					sent++;
				end else begin
					k   = run_kind_t'($urandom_range(0, 3));
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
						: $urandom_range(0, 7);
					n_bytes = (k == RUN_PAIRS) ? 2 * (len + 1)
						: (k == RUN_BOTH) ? 2 : len + 2;
					// now and then a run cut short
					if ($urandom_range(0, 7) == 0)
						n_bytes = $urandom_range(0, n_bytes);
					send_byte({k, 6'(len)}, 1'b0, NONE);
					repeat (n_bytes) send_byte(8'($urandom_range(0, 255)), 1'b0, NONE);
					sent += n_bytes + 1;
				end
			end
			n_phase++;
		end

		in_valid = 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("xbin_cell_stream_decoder_unit: match");
		else
			$display("xbin_cell_stream_decoder_unit: mismatch");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("xbin_cell_stream_decoder_unit: mismatch");
		$finish;
	end

endmodule
